// ===== sv/wwls_pkg.sv =====
// ----------------------------------------------------------------------------
// wwls_pkg
// shared types, register indexes and byte classification for the whole-word
// line search
// ----------------------------------------------------------------------------
package wwls_pkg;

  localparam int PatternMax = 16;
  localparam int WinDepth   = PatternMax + 1;
  localparam int LenW       = $clog2(PatternMax + 1);
  localparam int SelW       = $clog2(PatternMax);
  localparam int CountW     = 17;
  localparam logic [CountW-1:0] CountCap = CountW'(65536 + PatternMax);

  typedef logic [7:0] byte_t;

  // configuration register indexes
  localparam logic [1:0] RegPatternLow    = 2'd0;
  localparam logic [1:0] RegPatternHigh   = 2'd1;
  localparam logic [1:0] RegPatternLength = 2'd2;
  localparam logic [1:0] RegIgnoreCase    = 2'd3;

  localparam byte_t ByteNewline = 8'd10;

  // c-locale space or punctuation
  function automatic logic is_boundary(byte_t c);
    logic r;
    r = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) ||
        ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
        ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
    return r;
  endfunction

  // ascii upper case to lower case when folding is enabled
  function automatic byte_t fold_byte(byte_t c, logic fold_en);
    byte_t r;
    r = c;
    if (fold_en && (c >= 8'd65) && (c <= 8'd90)) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== sv/whole_word_line_search.sv =====
// ----------------------------------------------------------------------------
// whole_word_line_search
// finds a configured word of up to sixteen bytes, standing as a whole word,
// in a byte stream and reports the first hit of each line
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | in
//  in      | in_valid_i/in_ready_o, text_byte_i, end_of_input_i | in
//  out     | out_valid_o/out_ready_i, hit_line_o, match_column_o | out
//
// one byte per cycle while the result register is not stalled; a hit is
// loaded into the result register as its byte leaves the input register
// the window compare for all sixteen word lengths sits between the input
// register and the result register
// reset clears the window, the line and column counters and the valid flags
// of both registers; no clearing pass is needed
// a stalled result register holds the input register, which then drops
// in_ready_o; the configuration port is always ready
// ----------------------------------------------------------------------------
module whole_word_line_search import wwls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hit_line_o,
  output logic [15:0] match_column_o
);

  // configuration registers
  logic [63:0]   pat_low_q, pat_high_q;
  logic [4:0]    pat_len_q;
  logic          ign_case_q;

  // input register
  logic          s1_valid_q;
  byte_t         s1_byte_q;
  logic          s1_eoi_q;

  // search state
  byte_t              win_q [WinDepth];
  logic [CountW-1:0]  n_q;
  logic [31:0]        line_q;
  logic               reported_q;

  // result register
  logic          out_valid_q;
  logic [31:0]   out_line_q;
  logic [15:0]   out_col_q;

  logic          s1_fire;
  logic          in_fire;

  // word, folded
  byte_t             word_f [PatternMax];
  // window ending at the previous byte, and window ending at this byte
  byte_t             win_f  [PatternMax];
  byte_t             ext_f  [PatternMax];
  logic [PatternMax-1:0] hit_a, hit_b;

  logic              len_zero;
  logic [LenW-1:0]   len_eff, len_m1;
  logic [SelW-1:0]   len_sel;
  logic [CountW-1:0] len_x, len_m1_x;
  logic              ok_a, ok_b, found;
  logic [CountW-1:0] col_raw;
  logic [15:0]       col_sat;
  logic              line_end;

  assign cfg_ready_o = 1'b1;

  // ----------------------------------------------------------------------
  // handshakes
  // ----------------------------------------------------------------------
  // the input register moves on whenever the result register can take a slot
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // ----------------------------------------------------------------------
  // configuration
  // ----------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= 5'd1;
      ign_case_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPatternLow:    pat_low_q  <= cfg_data_i;
        RegPatternHigh:   pat_high_q <= cfg_data_i;
        RegPatternLength: pat_len_q  <= cfg_data_i[4:0];
        RegIgnoreCase:    ign_case_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------------------
  // compare logic
  // ----------------------------------------------------------------------
  // lengths above the maximum behave as the maximum, zero never matches
  assign len_zero = (pat_len_q == '0);
  assign len_eff  = (pat_len_q > 5'(PatternMax)) ? LenW'(PatternMax) : LenW'(pat_len_q);
  assign len_m1   = len_eff - LenW'(1);
  assign len_sel  = len_m1[SelW-1:0];
  assign len_x    = CountW'(len_eff);
  assign len_m1_x = CountW'(len_m1);

  always_comb begin
    for (int i = 0; i < PatternMax; i++) begin
      word_f[i] = (i < 8) ? fold_byte(pat_low_q[8*(i%8) +: 8], ign_case_q)
                          : fold_byte(pat_high_q[8*(i%8) +: 8], ign_case_q);
    end
    for (int k = 0; k < PatternMax; k++) begin
      win_f[k] = fold_byte(win_q[k], ign_case_q);
    end
    ext_f[0] = fold_byte(s1_byte_q, ign_case_q);
    for (int k = 1; k < PatternMax; k++) begin
      ext_f[k] = win_f[k-1];
    end
    // one match flag per candidate length, the word read backwards
    for (int l = 1; l <= PatternMax; l++) begin
      hit_a[l-1] = 1'b1;
      hit_b[l-1] = 1'b1;
      for (int i = 0; i < PatternMax; i++) begin
        if (i < l) begin
          if (word_f[i] != win_f[l-1-i]) hit_a[l-1] = 1'b0;
          if (word_f[i] != ext_f[l-1-i]) hit_b[l-1] = 1'b0;
        end
      end
    end
  end

  assign line_end = (s1_byte_q == ByteNewline) || s1_eoi_q;

  // word ended with the previous byte and this byte is a boundary after it
  assign ok_a = (n_q >= len_x) && is_boundary(s1_byte_q) && hit_a[len_sel] &&
                ((n_q == len_x) || is_boundary(win_q[len_eff]));

  // word ends with this byte, which closes the line
  assign ok_b = line_end && (n_q >= len_m1_x) && hit_b[len_sel] &&
                ((n_q == len_m1_x) || is_boundary(win_q[len_m1]));

  assign found   = !reported_q && !len_zero && (ok_a || ok_b);
  assign col_raw = ok_a ? (n_q - len_x) : (n_q - len_m1_x);
  assign col_sat = col_raw[CountW-1] ? 16'hffff : col_raw[15:0];

  // ----------------------------------------------------------------------
  // input register
  // ----------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_eoi_q  <= end_of_input_i;
    end
  end

  // ----------------------------------------------------------------------
  // window and line state
  // ----------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinDepth; k++) win_q[k] <= '0;
      n_q        <= '0;
      line_q     <= 32'd1;
      reported_q <= 1'b0;
    end else if (s1_fire) begin
      if (s1_eoi_q) begin
        // end of file, everything back to its reset value
        for (int k = 0; k < WinDepth; k++) win_q[k] <= '0;
        n_q        <= '0;
        line_q     <= 32'd1;
        reported_q <= 1'b0;
      end else begin
        win_q[0] <= s1_byte_q;
        for (int k = 1; k < WinDepth; k++) win_q[k] <= win_q[k-1];
        if (s1_byte_q == ByteNewline) begin
          n_q        <= '0;
          reported_q <= 1'b0;
          if (line_q != 32'hffff_ffff) line_q <= line_q + 32'd1;
        end else begin
          if (n_q < CountCap) n_q <= n_q + CountW'(1);
          if (found) reported_q <= 1'b1;
        end
      end
    end
  end

  // ----------------------------------------------------------------------
  // result register
  // ----------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= found;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && found) begin
      out_line_q <= line_q;
      out_col_q  <= col_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_line_o     = out_line_q;
  assign match_column_o = out_col_q;

  // ----------------------------------------------------------------------
  // assertions
  // ----------------------------------------------------------------------
  // the line counter never wraps to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != 32'd0)
    else $error("line counter reached zero");

  // a line is only marked reported by a transaction that produced a hit
  a_reported_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reported_q) |-> $past(s1_fire && found))
    else $error("line marked reported without a hit");

  // end of input returns the counters to their reset values
  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_eoi_q) |=> (line_q == 32'd1) && (n_q == '0) && !reported_q)
    else $error("state not cleared after end of input");

  // input stalls only behind a full pipeline held by the output side
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without back-pressure");

endmodule

// ===== verif/whole_word_line_search_tb.sv =====
// ----------------------------------------------------------------------------
// whole_word_line_search_tb
// self-checking bench for the whole-word line search: a byte stream goes in
// over a valid/ready channel, a line-local prediction of every whole-word hit
// is kept in a queue and each result transaction is checked against it;
// configuration is rewritten between phases, and both sides idle at random
// ----------------------------------------------------------------------------
module whole_word_line_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wwls_pkg::*;

  localparam int ResetCycles = 10;
  localparam int RunLimit    = 600000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 400;
  localparam int PhaseItems  = 155;
  localparam int RandPhases  = 8;
  localparam int LongFill    = 40;
  localparam int ReportCap   = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [31:0] line;
    logic [15:0] col;
  } hit_t;

  // dut ports, all inputs known from time zero
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = '0;
  logic [63:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i    = '0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] hit_line_o;
  logic [15:0] match_column_o;

  // stimulus and scoreboard
  text_item_t  text_q[$];
  hit_t        hits_due[$];
  logic [7:0]  line_buf[$];
  int          queued         = 0;
  int          errors         = 0;
  int          cycles         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  logic        hold_start     = 1'b0;

  // predictor copy of the registers
  logic [63:0] word_lo;
  logic [63:0] word_hi;
  logic [4:0]  word_len_reg;
  logic        fold_en;

  // predictor copy of the line state
  logic [7:0]  hist_q[WinDepth];   // most recent byte first
  logic [16:0] line_fill;
  logic [31:0] line_no;
  logic        line_done;

  whole_word_line_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_line_o     (hit_line_o),
    .match_column_o (match_column_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // space or punctuation in the c locale; nothing above 127 qualifies
  function automatic logic is_delim(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32, [8'd33:8'd47], [8'd58:8'd64],
                     [8'd91:8'd96], [8'd123:8'd126]};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (fold_en && (c inside {[8'd65:8'd90]})) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] word_at(input int i);
    return (i < 8) ? word_lo[8*i +: 8] : word_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic byte_eq(input logic [7:0] a, input logic [7:0] b);
    return to_lower(a) == to_lower(b);
  endfunction

  // one accepted byte: queue the hit it completes, then advance the line state
  function automatic void scan_byte(input logic [7:0] b, input logic eoi);
    int   len;
    int   n;
    int   col;
    logic hit;
    logic ok;
    len = (word_len_reg > 5'd16) ? 16 : int'(word_len_reg);
    n   = int'(line_fill);
    col = 0;
    hit = 1'b0;
    if (!line_done && len > 0) begin
      // word finished on the previous byte and this one closes it
      if (n >= len) begin
        ok = is_delim(b);
        for (int i = 0; i < len; i++) begin
          if (!byte_eq(word_at(i), hist_q[len-1-i])) ok = 1'b0;
        end
        if (n > len && !is_delim(hist_q[len])) ok = 1'b0;
        if (ok) begin
          hit = 1'b1;
          col = n - len;
        end
      end
      // word finishes on this byte, which is the last of its line
      if (!hit && (b == ByteNewline || eoi) && n + 1 >= len) begin
        ok = byte_eq(word_at(len-1), b);
        for (int i = 0; i + 1 < len; i++) begin
          if (!byte_eq(word_at(i), hist_q[len-2-i])) ok = 1'b0;
        end
        if (n + 1 > len && !is_delim(hist_q[len-1])) ok = 1'b0;
        if (ok) begin
          hit = 1'b1;
          col = n + 1 - len;
        end
      end
    end
    if (hit) begin
      hits_due.push_back('{line: line_no, col: (col > 65535) ? 16'hFFFF : 16'(col)});
      line_done = 1'b1;
    end
    for (int i = WinDepth - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
    hist_q[0] = b;
    if (line_fill < CountCap) line_fill = line_fill + 17'd1;
    if (eoi) begin
      foreach (hist_q[i]) hist_q[i] = 8'h00;
      line_fill = '0;
      line_no   = 32'd1;
      line_done = 1'b0;
    end else if (b == ByteNewline) begin
      if (line_no != 32'hFFFF_FFFF) line_no = line_no + 32'd1;
      line_fill = '0;
      line_done = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, predicts each one as its transaction completes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      text_byte_i    <= '0;
      end_of_input_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) scan_byte(text_byte_i, end_of_input_i);
      // payload only moves once the current byte has gone
      if (!in_valid_i || in_ready_o) begin
        if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          text_byte_i    <= text_q[0].data;
          end_of_input_i <= text_q[0].last;
          text_q.delete(0);
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes result transactions and checks them in order
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < ReportCap) begin
      $display("[%0t] %s: got %0d, wanted %0d", $realtime, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (hits_due.size() == 0) begin
          report_mismatch("result with no hit outstanding, line", hit_line_o, '0);
        end else begin
          if (hit_line_o !== hits_due[0].line) begin
            report_mismatch("hit_line", hit_line_o, hits_due[0].line);
          end
          if (match_column_o !== hits_due[0].col) begin
            report_mismatch("match_column", 32'(match_column_o), 32'(hits_due[0].col));
          end
          hits_due.delete(0);
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here so the sender keeps pushing
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // each call starts on a rising edge and returns on the edge of its transaction
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegPatternLow:    word_lo = data;
      RegPatternHigh:   word_hi = data;
      RegPatternLength: word_len_reg = data[4:0];
      RegIgnoreCase:    fold_en = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [63:0] len_data, input logic [63:0] fold_data);
    write_reg(RegPatternLow, lo);
    write_reg(RegPatternHigh, hi);
    write_reg(RegPatternLength, len_data);
    write_reg(RegIgnoreCase, fold_data);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every byte to be taken and every hit to come back
  task automatic drain();
    while (text_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_text(input logic [7:0] b, input logic eoi);
    text_q.push_back('{data: b, last: eoi});
  endtask

  function automatic logic [7:0] pick_delim();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'd32;
      1:       c = 8'($urandom_range(9, 13));
      2:       c = 8'($urandom_range(33, 47));
      3:       c = 8'($urandom_range(58, 64));
      4:       c = 8'($urandom_range(91, 96));
      default: c = 8'($urandom_range(123, 126));
    endcase
    return c;
  endfunction

  // bytes that never end a word
  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'($urandom_range(65, 90));
      1:       c = 8'($urandom_range(48, 57));
      2:       c = 8'h00;
      3:       c = 8'($urandom_range(127, 255));
      default: c = 8'($urandom_range(97, 122));
    endcase
    return c;
  endfunction

  // the search word, or a near miss: 1 cut short, 2 run on, 3 one byte off
  task automatic emit_word(input int mode);
    int         len;
    int         alt;
    logic [7:0] c;
    len = (word_len_reg > 5'd16) ? 16 : int'(word_len_reg);
    if (len == 0) len = 4;
    if (mode == 1 && len > 1) len--;
    alt = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      c = word_at(i);
      if (mode == 3 && i == alt) c = c + 8'd1;
      // swap letter case now and then
      if ((c inside {[8'd65:8'd90], [8'd97:8'd122]}) && $urandom_range(0, 3) == 0) begin
        c = c ^ 8'h20;
      end
      line_buf.push_back(c);
    end
    if (mode == 2) line_buf.push_back(pick_plain());
  endtask

  // one line of words and noise; the last line of a file carries end of input
  task automatic add_line(input logic file_end);
    int tokens;
    int r;
    line_buf.delete();
    tokens = $urandom_range(0, 6);
    for (int k = 0; k < tokens; k++) begin
      if ((k == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0)) begin
        line_buf.push_back(pick_delim());
      end
      r = $urandom_range(0, 9);
      if (r < 5) begin
        emit_word(0);
      end else if (r < 7) begin
        emit_word($urandom_range(1, 3));
      end else if (r < 9) begin
        repeat ($urandom_range(1, 4)) line_buf.push_back(pick_plain());
      end else begin
        repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (tokens != 0 && $urandom_range(0, 3) == 0) line_buf.push_back(pick_delim());
    if (!file_end || $urandom_range(0, 2) == 0) line_buf.push_back(ByteNewline);
    if (line_buf.size() == 0) line_buf.push_back(pick_plain());
    foreach (line_buf[j]) push_text(line_buf[j], file_end && (j == line_buf.size() - 1));
    queued += line_buf.size();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [127:0] word_bits;
    logic [63:0]  len_data;
    logic [63:0]  fold_data;
    int           len_val;

    // predictor at its reset values
    word_lo      = '0;
    word_hi      = '0;
    word_len_reg = 5'd1;
    fold_en      = 1'b0;
    foreach (hist_q[i]) hist_q[i] = 8'h00;
    line_fill    = '0;
    line_no      = 32'd1;
    line_done    = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset word is a single zero byte: zero is ordinary text, not a delimiter
    push_text(8'h00, 1'b0);
    push_text(ByteNewline, 1'b0);
    push_text("x", 1'b0);
    push_text(8'h00, 1'b0);
    push_text(ByteNewline, 1'b0);
    push_text(",", 1'b0);
    push_text(8'h00, 1'b1);
    // bytes above 127 never delimit
    push_text(8'h80, 1'b0);
    push_text(8'h00, 1'b0);
    push_text(ByteNewline, 1'b0);
    drain();

    // all-ones word, oversized length acting as the maximum, hit at end of input
    len_data       = {$urandom, $urandom};
    len_data[4:0]  = 5'd31;
    fold_data      = {$urandom, $urandom};
    fold_data[0]   = 1'b1;
    configure('1, '1, len_data, fold_data);
    for (int i = 0; i < 16; i++) push_text(8'hFF, i == 15);
    drain();

    // zero length never matches
    write_reg(RegPatternLength, 64'd0);
    cfg_valid_i <= 1'b0;
    push_text(8'hFF, 1'b0);
    push_text(ByteNewline, 1'b0);
    drain();

    // random phases, each with its own word and idling pattern
    for (int k = 0; k < RandPhases; k++) begin
      case (k)
        0:       len_val = 1;
        1:       len_val = 16;
        2:       len_val = 0;
        3:       len_val = $urandom_range(17, 31);
        default: len_val = $urandom_range(1, 16);
      endcase
      for (int i = 0; i < 16; i++) begin
        if (k == 4) begin
          word_bits[8*i +: 8] = 8'h00;
        end else if ($urandom_range(0, 9) < 7) begin
          word_bits[8*i +: 8] = pick_plain();
        end else begin
          word_bits[8*i +: 8] = 8'($urandom_range(0, 255));
        end
      end
      len_data      = {$urandom, $urandom};
      len_data[4:0] = 5'(len_val);
      fold_data     = {$urandom, $urandom};
      if (k < 2) fold_data[0] = (k == 0);
      configure(word_bits[63:0], word_bits[127:64], len_data, fold_data);

      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase

      queued = 0;
      while (queued < PhaseItems) add_line($urandom_range(0, 5) == 0);
      // back-pressure run: the receiver stops long enough for the input to stall
      if (k == 4) begin
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      drain();
    end

    // a long run of spaces before the word, then the word at end of input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(64'h0000_0000_0063_6261, '0, 64'd3, 64'd0);
    repeat (LongFill) push_text(8'd32, 1'b0);
    push_text("a", 1'b0);
    push_text("b", 1'b0);
    push_text("c", 1'b0);
    push_text(ByteNewline, 1'b0);
    push_text("a", 1'b0);
    push_text("b", 1'b0);
    push_text("c", 1'b1);
    drain();

    repeat (20) @(posedge clk_i);
    if (errors == 0 && hits_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== whole_word_line_search.f =====
sv/wwls_pkg.sv
sv/whole_word_line_search.sv
verif/whole_word_line_search_tb.sv
